// ===== src/poram_pkg.sv =====
package poram_pkg;

  // default geometry
  localparam int TreeLevels   = 7;
  localparam int BucketSlots  = 4;
  localparam int StashDepth   = 64;
  localparam int AddressSpace = 1024;
  localparam int PayloadWidth = 64;

  // fixed port widths
  localparam int ModeW    = 2;
  localparam int PortAddrW = 10;
  localparam int PortDataW = 64;
  localparam int PortLeafW = 7;

  // access modes
  localparam logic [ModeW-1:0] MODE_READ  = 2'd0;
  localparam logic [ModeW-1:0] MODE_WRITE = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_PATH,
    ST_SWEEP,
    ST_VIRT,
    ST_PAD,
    ST_DONE
  } poram_state_e;

endpackage

// ===== src/path_oram_access.sv =====
// path oram access controller: busy while working, one done_o strobe per accepted word
// dummy word (mode 2 or 3, or address out of range): done_o in the cycle after acceptance
// real word: read the old mapping, read the (TREE_LEVELS+1)*BUCKET_SLOTS slots of the path, then per
// level a stash sweep and a pad of each empty slot, an append of a missing write block after the
// leaf level's sweep, and the done_o strobe; busy holds after reset while the map and tree tags
// are cleared, no stall
module path_oram_access #(
  parameter int TREE_LEVELS   = poram_pkg::TreeLevels,
  parameter int BUCKET_SLOTS  = poram_pkg::BucketSlots,
  parameter int STASH_DEPTH   = poram_pkg::StashDepth,
  parameter int ADDRESS_SPACE = poram_pkg::AddressSpace,
  parameter int PAYLOAD_WIDTH = poram_pkg::PayloadWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [poram_pkg::ModeW-1:0]     mode_i,
  input  logic [poram_pkg::PortAddrW-1:0] block_address_i,
  input  logic [poram_pkg::PortDataW-1:0] write_data_i,
  input  logic [poram_pkg::PortLeafW-1:0] fresh_leaf_i,
  output logic                            done_o,
  output logic [poram_pkg::PortDataW-1:0] read_data_o,
  output logic                            status_o
);

  // geometry
  localparam int LW    = TREE_LEVELS;
  localparam int AW    = $clog2(ADDRESS_SPACE);
  localparam int PW    = PAYLOAD_WIDTH;
  localparam int NODES = (2 << TREE_LEVELS) - 1;
  localparam int SLOTS = NODES * BUCKET_SLOTS;
  localparam int SAW   = $clog2(SLOTS);
  localparam int IW    = $clog2(STASH_DEPTH);
  localparam int CW    = $clog2(STASH_DEPTH + 1);
  localparam int LVW   = $clog2(TREE_LEVELS + 1);
  localparam int FW    = $clog2(BUCKET_SLOTS + 1);
  localparam int CLRN  = (ADDRESS_SPACE > SLOTS) ? ADDRESS_SPACE : SLOTS;
  localparam int CLW   = $clog2(CLRN);
  localparam int MTW   = 1 + LW;        // map entry: valid, leaf
  localparam int STW   = AW + LW;       // stash tag: address, cached leaf
  localparam int TTW   = 1 + STW;       // tree tag: valid, address, cached leaf

  poram_pkg::poram_state_e state_q, state_d;

  // request
  logic          write_q, write_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [PW-1:0] data_q, data_d;
  logic [LW-1:0] fresh_q, fresh_d;
  logic [LW-1:0] x_q, x_d;              // path leaf
  logic [PW-1:0] rdata_q, rdata_d;
  logic          ovf_q, ovf_d;
  logic          found_q, found_d;

  // sequencer counters
  logic [CLW-1:0] clr_q, clr_d;
  logic [LVW-1:0] lv_q, lv_d;
  logic [FW-1:0]  f_q, f_d;             // slot within bucket
  logic           issue_done_q, issue_done_d;
  logic           rd_v_q, rd_v_d;       // read issued last cycle
  logic [CW-1:0]  cnt_q, cnt_d;         // stash fill
  logic [CW-1:0]  i_q, i_d;             // sweep read index
  logic [CW-1:0]  w_q, w_d;             // sweep compaction index
  logic [CW-1:0]  n_q, n_d;             // entries in this sweep

  // memory ports
  logic           map_we;
  logic [AW-1:0]  map_waddr, map_raddr;
  logic [MTW-1:0] map_wdata, map_rdata;
  logic           tt_we, tp_we;
  logic [SAW-1:0] tt_waddr, tt_raddr;
  logic [TTW-1:0] tt_wdata, tt_rdata;
  logic [PW-1:0]  tp_wdata, tp_rdata;
  logic           st_we;
  logic [IW-1:0]  st_waddr, st_raddr;
  logic [STW-1:0] st_wtag, st_rtag;
  logic [PW-1:0]  st_wpay, st_rpay;

  // bucket address of the current level
  logic [SAW-1:0] node_w, slot_addr;
  logic [LVW-1:0] shamt;

  // placement decision for one stash entry
  logic [AW-1:0]  ent_a;
  logic [LW-1:0]  ent_leaf, leaf_eff;
  logic [PW-1:0]  ent_pay, pay_eff;
  logic           is_req, drop_rd, place;
  logic           is_real;
  logic           sweep_end;

  poram_ram #(.WIDTH(MTW), .DEPTH(ADDRESS_SPACE)) u_map (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .raddr_i(map_raddr),
    .rdata_o(map_rdata)
  );

  poram_ram #(.WIDTH(TTW), .DEPTH(SLOTS)) u_tree_tag (
    .clk_i  (clk_i),
    .we_i   (tt_we),
    .waddr_i(tt_waddr),
    .wdata_i(tt_wdata),
    .raddr_i(tt_raddr),
    .rdata_o(tt_rdata)
  );

  poram_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_tree_pay (
    .clk_i  (clk_i),
    .we_i   (tp_we),
    .waddr_i(tt_waddr),
    .wdata_i(tp_wdata),
    .raddr_i(tt_raddr),
    .rdata_o(tp_rdata)
  );

  poram_ram #(.WIDTH(STW), .DEPTH(STASH_DEPTH)) u_stash_tag (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wtag),
    .raddr_i(st_raddr),
    .rdata_o(st_rtag)
  );

  poram_ram #(.WIDTH(PW), .DEPTH(STASH_DEPTH)) u_stash_pay (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wpay),
    .raddr_i(st_raddr),
    .rdata_o(st_rpay)
  );

  // modes 2 and 3 and out-of-range addresses do nothing
  assign is_real = ((mode_i == poram_pkg::MODE_READ) || (mode_i == poram_pkg::MODE_WRITE))
                   && (32'(block_address_i) < 32'(ADDRESS_SPACE));

  // heap node of the path at level lv_q, then its first slot
  assign shamt     = LVW'(TREE_LEVELS) - lv_q;
  assign node_w    = ((SAW'(1) << lv_q) - SAW'(1)) + (SAW'(x_q) >> shamt);
  assign slot_addr = SAW'(node_w * SAW'(BUCKET_SLOTS)) + SAW'(f_q);

  assign sweep_end = (i_q == n_q) && !rd_v_q;

  // entry under decision: the stash word just read, or the re-inserted block
  always_comb begin
    if (state_q == poram_pkg::ST_VIRT) begin
      ent_a    = addr_q;
      ent_leaf = fresh_q;
      ent_pay  = data_q;
    end else begin
      ent_a    = st_rtag[STW-1:LW];
      ent_leaf = st_rtag[LW-1:0];
      ent_pay  = st_rpay;
    end
    // the requested block carries its new leaf and, on a write, the new data
    is_req   = (ent_a == addr_q);
    drop_rd  = is_req && !write_q;
    leaf_eff = is_req ? fresh_q : ent_leaf;
    pay_eff  = (is_req && write_q) ? data_q : ent_pay;
    // level-prefix test against the path leaf
    place    = (f_q < FW'(BUCKET_SLOTS)) && ((leaf_eff >> shamt) == (x_q >> shamt));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      poram_pkg::ST_CLEAR: begin
        if (clr_q == CLW'(CLRN - 1)) state_d = poram_pkg::ST_IDLE;
      end
      poram_pkg::ST_IDLE: begin
        if (start) state_d = is_real ? poram_pkg::ST_MAP : poram_pkg::ST_DONE;
      end
      poram_pkg::ST_MAP: state_d = poram_pkg::ST_PATH;
      poram_pkg::ST_PATH: begin
        if (issue_done_q && !rd_v_q) state_d = poram_pkg::ST_SWEEP;
      end
      poram_pkg::ST_SWEEP: begin
        if (sweep_end) begin
          // a write whose block is gone gets appended after the first sweep
          if ((lv_q == LVW'(TREE_LEVELS)) && write_q && !found_q) begin
            state_d = poram_pkg::ST_VIRT;
          end else begin
            state_d = poram_pkg::ST_PAD;
          end
        end
      end
      poram_pkg::ST_VIRT: state_d = poram_pkg::ST_PAD;
      poram_pkg::ST_PAD: begin
        if (f_q == FW'(BUCKET_SLOTS)) begin
          state_d = (lv_q == '0) ? poram_pkg::ST_DONE : poram_pkg::ST_SWEEP;
        end
      end
      poram_pkg::ST_DONE: state_d = poram_pkg::ST_IDLE;
      default: state_d = poram_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    write_d      = write_q;
    addr_d       = addr_q;
    data_d       = data_q;
    fresh_d      = fresh_q;
    x_d          = x_q;
    rdata_d      = rdata_q;
    ovf_d        = ovf_q;
    found_d      = found_q;
    clr_d        = clr_q;
    lv_d         = lv_q;
    f_d          = f_q;
    issue_done_d = issue_done_q;
    rd_v_d       = 1'b0;
    cnt_d        = cnt_q;
    i_d          = i_q;
    w_d          = w_q;
    n_d          = n_q;

    map_we    = 1'b0;
    map_waddr = addr_q;
    map_wdata = '0;
    map_raddr = AW'(block_address_i);
    tt_we     = 1'b0;
    tp_we     = 1'b0;
    tt_waddr  = slot_addr;
    tt_raddr  = slot_addr;
    tt_wdata  = '0;
    tp_wdata  = pay_eff;
    st_we     = 1'b0;
    st_waddr  = cnt_q[IW-1:0];
    st_raddr  = i_q[IW-1:0];
    st_wtag   = '0;
    st_wpay   = data_q;

    case (state_q)
      poram_pkg::ST_CLEAR: begin
        // one map entry and one tree tag per cycle
        map_we    = 32'(clr_q) < 32'(ADDRESS_SPACE);
        map_waddr = AW'(clr_q);
        tt_we     = 32'(clr_q) < 32'(SLOTS);
        tt_waddr  = SAW'(clr_q);
        clr_d     = clr_q + CLW'(1);
      end
      poram_pkg::ST_IDLE: begin
        if (start) begin
          write_d = (mode_i == poram_pkg::MODE_WRITE);
          addr_d  = AW'(block_address_i);
          data_d  = PW'(write_data_i);
          fresh_d = LW'(fresh_leaf_i);
          rdata_d = '0;
          ovf_d   = 1'b0;
          found_d = 1'b0;
        end
      end
      poram_pkg::ST_MAP: begin
        // old mapping arrives; remap, or unmap on a read
        x_d       = map_rdata[MTW-1] ? map_rdata[LW-1:0] : fresh_q;
        map_we    = 1'b1;
        map_wdata = write_q ? {1'b1, fresh_q} : '0;
        if (!map_rdata[MTW-1]) begin
          if (cnt_q < CW'(STASH_DEPTH)) begin
            st_we   = 1'b1;
            st_wtag = {addr_q, fresh_q};
            st_wpay = data_q;
            cnt_d   = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        lv_d         = '0;
        f_d          = '0;
        issue_done_d = 1'b0;
      end
      poram_pkg::ST_PATH: begin
        // issue one slot read a cycle, root to leaf
        if (!issue_done_q) begin
          rd_v_d = 1'b1;
          if (f_q == FW'(BUCKET_SLOTS - 1)) begin
            f_d = '0;
            if (lv_q == LVW'(TREE_LEVELS)) issue_done_d = 1'b1;
            else lv_d = lv_q + LVW'(1);
          end else begin
            f_d = f_q + FW'(1);
          end
        end
        // real blocks of the path go to the stash tail
        if (rd_v_q && tt_rdata[TTW-1]) begin
          if (cnt_q < CW'(STASH_DEPTH)) begin
            st_we   = 1'b1;
            st_wtag = tt_rdata[STW-1:0];
            st_wpay = tp_rdata;
            cnt_d   = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        if (issue_done_q && !rd_v_q) begin
          lv_d = LVW'(TREE_LEVELS);
          f_d  = '0;
          i_d  = '0;
          w_d  = '0;
          n_d  = cnt_q;
        end
      end
      poram_pkg::ST_SWEEP, poram_pkg::ST_VIRT: begin
        if ((state_q == poram_pkg::ST_SWEEP) && (i_q < n_q)) begin
          i_d    = i_q + CW'(1);
          rd_v_d = 1'b1;
        end
        if ((state_q == poram_pkg::ST_SWEEP) ? rd_v_q : (n_q < CW'(STASH_DEPTH))) begin
          if (is_req) found_d = 1'b1;
          if (drop_rd) begin
            rdata_d = ent_pay;
          end else if (place) begin
            tt_we    = 1'b1;
            tp_we    = 1'b1;
            tt_wdata = {1'b1, ent_a, leaf_eff};
            f_d      = f_q + FW'(1);
          end else begin
            // keep in the stash, packed toward the front
            st_we    = 1'b1;
            st_waddr = w_q[IW-1:0];
            st_wtag  = {ent_a, leaf_eff};
            st_wpay  = pay_eff;
            w_d      = w_q + CW'(1);
          end
        end else if (state_q == poram_pkg::ST_VIRT) begin
          ovf_d = 1'b1;
        end
      end
      poram_pkg::ST_PAD: begin
        if (f_q < FW'(BUCKET_SLOTS)) begin
          tt_we = 1'b1;
          f_d   = f_q + FW'(1);
        end else begin
          cnt_d = w_q;
          f_d   = '0;
          i_d   = '0;
          w_d   = '0;
          n_d   = w_q;
          if (lv_q != '0) lv_d = lv_q - LVW'(1);
        end
      end
      poram_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= poram_pkg::ST_CLEAR;
      clr_q        <= '0;
      lv_q         <= '0;
      f_q          <= '0;
      issue_done_q <= 1'b0;
      rd_v_q       <= 1'b0;
      cnt_q        <= '0;
      i_q          <= '0;
      w_q          <= '0;
      n_q          <= '0;
      ovf_q        <= 1'b0;
      found_q      <= 1'b0;
      rdata_q      <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      lv_q         <= lv_d;
      f_q          <= f_d;
      issue_done_q <= issue_done_d;
      rd_v_q       <= rd_v_d;
      cnt_q        <= cnt_d;
      i_q          <= i_d;
      w_q          <= w_d;
      n_q          <= n_d;
      ovf_q        <= ovf_d;
      found_q      <= found_d;
      rdata_q      <= rdata_d;
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    write_q <= write_d;
    addr_q  <= addr_d;
    data_q  <= data_d;
    fresh_q <= fresh_d;
    x_q     <= x_d;
  end

  assign busy        = (state_q != poram_pkg::ST_IDLE);
  assign done_o      = (state_q == poram_pkg::ST_DONE);
  assign read_data_o = poram_pkg::PortDataW'(rdata_q);
  assign status_o    = ovf_q;

`ifndef SYNTH
  a_stash_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STASH_DEPTH)) else $error("stash count past depth");

  a_compact_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == poram_pkg::ST_SWEEP) |-> (w_q <= i_q))
    else $error("stash compaction overtook the read index");

  a_bucket_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_q <= FW'(BUCKET_SLOTS)) else $error("bucket fill past slot count");

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("done not followed by idle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");
`endif

endmodule

// ===== src/poram_ram.sv =====
module poram_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
